FILE: sv/hphm_pkg.sv
// Shared types, constants and helpers for the hot pixel history masker.
// Used by hot_pixel_history_masker_unit and the testbench files; no dependencies.
package hphm_pkg;

    // Default geometry, handed to the top level as parameter defaults.
    localparam int unsigned NUM_PIXELS_DEFAULT     = 4096;
    localparam int unsigned HISTORY_FRAMES_DEFAULT = 32;

    // Fixed field widths.
    localparam int unsigned PIX_IDX_W   = 12;
    localparam int unsigned SAMPLE_W    = 16;
    localparam int unsigned THRESH_W    = 16;
    localparam int unsigned CUTOFF_W    = 7;
    localparam int unsigned TOTAL_W     = 13;
    localparam int unsigned FRAME_CNT_W = 32;
    localparam int unsigned CFG_DATA_W  = 16;

    // Register reset values and the saturation point of the masked count.
    localparam logic [THRESH_W-1:0] HOT_THRESHOLD_RESET    = 16'd32767;
    localparam logic [CUTOFF_W-1:0] HOT_COUNT_CUTOFF_RESET = 7'd32;
    localparam logic [TOTAL_W-1:0]  TOTAL_MAX              = '1;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_HOT_THRESHOLD    = 1'b0,
        CFG_HOT_COUNT_CUTOFF = 1'b1
    } cfg_index_t;

    // Request actions.
    typedef enum logic [0:0] {
        ACT_SAMPLE    = 1'b0,
        ACT_RECOMPUTE = 1'b1
    } action_t;

    // Input request payload.
    typedef struct packed {
        action_t                     action;
        logic [PIX_IDX_W-1:0]        pixel_index;
        logic signed [SAMPLE_W-1:0]  pixel_value;
        logic                        end_of_frame;
    } in_t;

    // Result payload.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0]  corrected_value;
        logic [TOTAL_W-1:0]          hot_pixel_count;
        logic [FRAME_CNT_W-1:0]      frames_seen;
        logic                        mask_updated;
    } out_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SAMPLE,
        ST_SWEEP,
        ST_FINISH
    } state_t;

    // A sample is hot when its magnitude is strictly above the threshold.
    // The most negative sample has magnitude 32768.
    function automatic logic hot_detect(input logic [SAMPLE_W-1:0] value,
                                        input logic [THRESH_W-1:0] threshold);
        logic [SAMPLE_W:0] mag;
        begin
            if (value[SAMPLE_W-1])
            begin
                mag = (SAMPLE_W+1)'((SAMPLE_W+1)'(1) << SAMPLE_W) - {1'b0, value};
            end
            else
            begin
                mag = {1'b0, value};
            end
            hot_detect = (mag > {1'b0, threshold});
        end
    endfunction

endpackage

FILE: sv/hphm_entry_ram.sv
// Per-pixel state memory: one write port and one registered read port.
// Depends on nothing but its parameters; instantiated by the top level.
module hphm_entry_ram #(
    parameter int unsigned DEPTH  = 4096,
    parameter int unsigned WIDTH  = 39,
    parameter int unsigned ADDR_W = 12
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rd_data_reg;

    // Synchronous write and read; the read data is registered.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/hot_pixel_history_masker_unit.sv
// Top level of the hot pixel history masker: controller, registers, result stage.
// Depends on hphm_pkg and instantiates hphm_entry_ram.
//
// Usage:
//   Requests enter on in_valid/in_stall/in_data and results leave on
//   out_valid/out_stall/out_data; each request gives exactly one result.
//   A pixel sample reads the pixel's entry (history ring, hot-frame tally,
//   mask bit) from the state memory when accepted; in ST_SAMPLE, once the
//   output register is free, it writes the updated entry back and loads
//   the result register. No new sample is accepted before that write-back,
//   limited by the read-modify-write of the single-port-pair state memory.
//   A recompute request streams through every entry, one per cycle, and
//   loads its result once the sweep ends and the output register is free.
//   After reset the block runs a clearing pass over every entry of the
//   state memory and holds in_stall high until it is done.
//   Configuration writes on cfg_we/cfg_index/cfg_data take effect at once
//   and are accepted whenever rst_n is high, the clearing pass included.
//   A stalled result waits in the output register; the next request is
//   accepted meanwhile and its result is held back until the register frees.
module hot_pixel_history_masker_unit
    import hphm_pkg::*;
#(
    parameter int unsigned NUM_PIXELS     = NUM_PIXELS_DEFAULT,
    parameter int unsigned HISTORY_FRAMES = HISTORY_FRAMES_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  cfg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_t                   in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_t                  out_data
);

    // Derived widths.
    localparam int unsigned ADDR_W    = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
    localparam int unsigned PIX_EXT_W = ((ADDR_W > PIX_IDX_W) ? ADDR_W : PIX_IDX_W) + 1;
    localparam int unsigned CNT_W     = $clog2(NUM_PIXELS + 1);
    localparam int unsigned SLOT_W    = (HISTORY_FRAMES > 1) ? $clog2(HISTORY_FRAMES) : 1;
    localparam int unsigned TALLY_W   = $clog2(HISTORY_FRAMES + 1);
    localparam int unsigned ENTRY_W   = HISTORY_FRAMES + TALLY_W + 1;
    localparam int unsigned TALLY_LSB = HISTORY_FRAMES;
    localparam int unsigned GOOD_BIT  = HISTORY_FRAMES + TALLY_W;

    localparam logic [CNT_W-1:0]       CNT_LAST  = CNT_W'(NUM_PIXELS - 1);
    localparam logic [CNT_W-1:0]       CNT_END   = CNT_W'(NUM_PIXELS);
    localparam logic [PIX_EXT_W-1:0]   PIX_LIMIT = PIX_EXT_W'(NUM_PIXELS);
    localparam logic [SLOT_W-1:0]      SLOT_LAST = SLOT_W'(HISTORY_FRAMES - 1);
    localparam logic [ENTRY_W-1:0]     ENTRY_CLEAR = ENTRY_W'(1) << GOOD_BIT;

    // Registers.
    state_t                 state_reg, state_next;
    logic [THRESH_W-1:0]    threshold_reg, threshold_next;
    logic [CUTOFF_W-1:0]    cutoff_reg, cutoff_next;
    in_t                    item_reg, item_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   wr_pend_reg, wr_pend_next;
    logic [ADDR_W-1:0]      wr_addr_reg, wr_addr_next;
    logic [TOTAL_W-1:0]     total_reg, total_next;
    logic [TOTAL_W-1:0]     masked_total_reg, masked_total_next;
    logic [FRAME_CNT_W-1:0] frame_count_reg, frame_count_next;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic                   out_valid_reg, out_valid_next;
    out_t                   out_data_reg, out_data_next;

    // Memory port signals.
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_wr_addr;
    logic [ENTRY_W-1:0]     ram_wr_data;
    logic [ADDR_W-1:0]      ram_rd_addr;
    logic [ENTRY_W-1:0]     ram_rd_data;

    // Decoded request and entry fields.
    logic                   accept;
    logic                   out_free;
    logic [PIX_EXT_W-1:0]   in_pix_ext;
    logic [PIX_EXT_W-1:0]   item_pix_ext;
    logic                   item_in_range;
    logic                   sample_hot;
    logic                   sweep_issue;
    logic [HISTORY_FRAMES-1:0] rd_hist;
    logic [TALLY_W-1:0]     rd_tally;
    logic                   rd_good;
    logic [HISTORY_FRAMES-1:0] new_hist;
    logic [TALLY_W-1:0]     new_tally;
    logic                   old_bit;
    logic                   masked_now;

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign in_pix_ext    = PIX_EXT_W'(in_data.pixel_index);
    assign item_pix_ext  = PIX_EXT_W'(item_reg.pixel_index);
    assign item_in_range = (item_pix_ext < PIX_LIMIT);
    assign sample_hot    = hot_detect(item_reg.pixel_value, threshold_reg);
    assign sweep_issue   = (cnt_reg < CNT_END);

    // Fields of the entry that the memory returns.
    assign rd_hist  = ram_rd_data[HISTORY_FRAMES-1:0];
    assign rd_tally = ram_rd_data[GOOD_BIT-1:TALLY_LSB];
    assign rd_good  = ram_rd_data[GOOD_BIT];

    // Sample update: replace this frame's history bit and adjust the tally.
    always_comb
    begin
        old_bit  = rd_hist[slot_reg];
        new_hist = rd_hist;
        new_hist[slot_reg] = sample_hot;
        new_tally = rd_tally - TALLY_W'(old_bit) + TALLY_W'(sample_hot);
    end

    // Recompute decision for the entry that the memory returns.
    assign masked_now = (CUTOFF_W'(rd_tally) >= cutoff_reg);

    // Configuration registers.
    always_comb
    begin
        threshold_next = threshold_reg;
        cutoff_next    = cutoff_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HOT_THRESHOLD:    threshold_next = cfg_data[THRESH_W-1:0];
                CFG_HOT_COUNT_CUTOFF: cutoff_next    = cfg_data[CUTOFF_W-1:0];
            endcase
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (in_data.action == ACT_RECOMPUTE) ? ST_SWEEP : ST_SAMPLE;
                end
            end
            ST_SAMPLE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SWEEP:
            begin
                if (!sweep_issue && !wr_pend_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Output logic: memory control, counters and the result register load.
    always_comb
    begin
        in_stall          = (state_reg != ST_IDLE);
        item_next         = item_reg;
        cnt_next          = cnt_reg;
        wr_pend_next      = 1'b0;
        wr_addr_next      = wr_addr_reg;
        total_next        = total_reg;
        masked_total_next = masked_total_reg;
        frame_count_next  = frame_count_reg;
        slot_next         = slot_reg;
        out_valid_next    = out_valid_reg && out_stall;
        out_data_next     = out_data_reg;
        ram_we            = 1'b0;
        ram_wr_addr       = cnt_reg[ADDR_W-1:0];
        ram_wr_data       = ENTRY_CLEAR;
        ram_rd_addr       = in_pix_ext[ADDR_W-1:0];

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we   = 1'b1;
                cnt_next = (cnt_reg == CNT_LAST) ? '0 : cnt_reg + CNT_W'(1);
            end
            ST_IDLE:
            begin
                // The input is never stalled here, so a valid request is taken.
                if (in_valid)
                begin
                    item_next  = in_data;
                    cnt_next   = '0;
                    total_next = '0;
                end
            end
            ST_SAMPLE:
            begin
                ram_rd_addr = item_pix_ext[ADDR_W-1:0];
                if (out_free)
                begin
                    ram_we      = item_in_range;
                    ram_wr_addr = item_pix_ext[ADDR_W-1:0];
                    ram_wr_data = {rd_good, new_tally, new_hist};
                    if (item_reg.end_of_frame)
                    begin
                        frame_count_next = frame_count_reg + FRAME_CNT_W'(1);
                        if (frame_count_reg == '1 || slot_reg == SLOT_LAST)
                        begin
                            slot_next = '0;
                        end
                        else
                        begin
                            slot_next = slot_reg + SLOT_W'(1);
                        end
                    end
                    out_valid_next = 1'b1;
                    out_data_next.corrected_value =
                        (item_in_range && !rd_good) ? '0 : item_reg.pixel_value;
                    out_data_next.hot_pixel_count = masked_total_reg;
                    out_data_next.frames_seen     = frame_count_next;
                    out_data_next.mask_updated    = 1'b0;
                end
            end
            ST_SWEEP:
            begin
                // Read entry cnt while writing back the entry read last cycle.
                ram_rd_addr  = cnt_reg[ADDR_W-1:0];
                wr_pend_next = sweep_issue;
                wr_addr_next = cnt_reg[ADDR_W-1:0];
                if (sweep_issue)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                if (wr_pend_reg)
                begin
                    ram_we      = 1'b1;
                    ram_wr_addr = wr_addr_reg;
                    ram_wr_data = {!masked_now, rd_tally, rd_hist};
                    if (masked_now && total_reg != TOTAL_MAX)
                    begin
                        total_next = total_reg + TOTAL_W'(1);
                    end
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    masked_total_next             = total_reg;
                    out_valid_next                = 1'b1;
                    out_data_next.corrected_value = '0;
                    out_data_next.hot_pixel_count = total_reg;
                    out_data_next.frames_seen     = frame_count_reg;
                    out_data_next.mask_updated    = 1'b1;
                end
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            threshold_reg    <= HOT_THRESHOLD_RESET;
            cutoff_reg       <= HOT_COUNT_CUTOFF_RESET;
            cnt_reg          <= '0;
            wr_pend_reg      <= 1'b0;
            total_reg        <= '0;
            masked_total_reg <= '0;
            frame_count_reg  <= '0;
            slot_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            threshold_reg    <= threshold_next;
            cutoff_reg       <= cutoff_next;
            cnt_reg          <= cnt_next;
            wr_pend_reg      <= wr_pend_next;
            total_reg        <= total_next;
            masked_total_reg <= masked_total_next;
            frame_count_reg  <= frame_count_next;
            slot_reg         <= slot_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        wr_addr_reg  <= wr_addr_next;
        out_data_reg <= out_data_next;
    end

    // Per-pixel state: history ring, hot-frame tally and good-mask bit.
    hphm_entry_ram #(
        .DEPTH  (NUM_PIXELS),
        .WIDTH  (ENTRY_W),
        .ADDR_W (ADDR_W)
    ) u_entry_ram (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: tb/hot_pixel_mask_checker.sv
// Checker for the hot pixel history masker: follows the request, result and register ports,
// predicts each result and compares it field by field. Depends on hphm_pkg.
module hot_pixel_mask_checker
    import hphm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  cfg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  in_t                   in_data,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  out_t                  out_data,
    output int                    outputs_in_flight,
    output int                    mismatch_count
);

    localparam int unsigned PIXELS = NUM_PIXELS_DEFAULT;
    localparam int unsigned FRAMES = HISTORY_FRAMES_DEFAULT;

    // Register copies and the per-pixel state of the masker.
    logic [THRESH_W-1:0]    threshold_reg;
    logic [CUTOFF_W-1:0]    cutoff_reg;
    bit                     hot_ring [FRAMES][PIXELS];
    logic [5:0]             hot_tally [PIXELS];
    bit                     pixel_good [PIXELS];
    logic [FRAME_CNT_W-1:0] frame_total;
    logic [TOTAL_W-1:0]     masked_pixels;
    out_t                   predicted_outputs [$];

    // Applies one request to the state and returns the result it must produce.
    function automatic out_t predict_masker_output(input in_t req);
        out_t        res;
        int          level;
        int unsigned magnitude;
        int unsigned slot;
        int unsigned pixel;
        int unsigned masked;
        bit          is_hot;
        begin
            res = '0;
            if (req.action == ACT_RECOMPUTE)
            begin
                // Rebuild the whole mask and count the masked pixels, saturating.
                masked = 0;
                for (int p = 0; p < PIXELS; p++)
                begin
                    if (CUTOFF_W'(hot_tally[p]) < cutoff_reg)
                    begin
                        pixel_good[p] = 1'b1;
                    end
                    else
                    begin
                        pixel_good[p] = 1'b0;
                        if (masked < 32'(TOTAL_MAX))
                        begin
                            masked++;
                        end
                    end
                end
                masked_pixels = TOTAL_W'(masked);
                res.mask_updated = 1'b1;
            end
            else
            begin
                // A sample is hot when its magnitude is strictly above the threshold.
                level = int'(req.pixel_value);
                magnitude = (level < 0) ? -level : level;
                is_hot = (magnitude > 32'(threshold_reg));
                res.corrected_value = req.pixel_value;
                pixel = 32'(req.pixel_index);
                if (pixel < PIXELS)
                begin
                    // Replace this frame's slot bit and keep the tally in step with the ring.
                    slot = frame_total % FRAMES;
                    hot_tally[pixel] = hot_tally[pixel] - 6'(hot_ring[slot][pixel]) + 6'(is_hot);
                    hot_ring[slot][pixel] = is_hot;
                    if (!pixel_good[pixel])
                    begin
                        res.corrected_value = '0;
                    end
                end
                if (req.end_of_frame)
                begin
                    frame_total++;
                end
            end
            res.hot_pixel_count = masked_pixels;
            res.frames_seen = frame_total;
            return res;
        end
    endfunction

    // Reports one field that differs from its prediction.
    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        begin
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatch_count++;
            end
        end
    endtask

    // Track register writes, predict accepted requests and check accepted results.
    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        if (!rst_n)
        begin
            threshold_reg = HOT_THRESHOLD_RESET;
            cutoff_reg = HOT_COUNT_CUTOFF_RESET;
            for (int f = 0; f < FRAMES; f++)
            begin
                for (int p = 0; p < PIXELS; p++)
                begin
                    hot_ring[f][p] = 1'b0;
                end
            end
            for (int p = 0; p < PIXELS; p++)
            begin
                hot_tally[p] = '0;
                pixel_good[p] = 1'b1;
            end
            frame_total = '0;
            masked_pixels = '0;
            predicted_outputs.delete();
            outputs_in_flight = 0;
            mismatch_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_HOT_THRESHOLD:    threshold_reg = cfg_data[THRESH_W-1:0];
                    CFG_HOT_COUNT_CUTOFF: cutoff_reg = cfg_data[CUTOFF_W-1:0];
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (predicted_outputs.size() == 0)
                begin
                    $error("result with no request waiting: corrected_value %0d, frames_seen %0d",
                           $signed(out_data.corrected_value), out_data.frames_seen);
                    mismatch_count++;
                end
                else
                begin
                    want = predicted_outputs.pop_front();
                    check_field("corrected_value", 64'(want.corrected_value),
                                64'(out_data.corrected_value));
                    check_field("hot_pixel_count", 64'(want.hot_pixel_count),
                                64'(out_data.hot_pixel_count));
                    check_field("frames_seen", 64'(want.frames_seen),
                                64'(out_data.frames_seen));
                    check_field("mask_updated", 64'(want.mask_updated),
                                64'(out_data.mask_updated));
                end
            end
            if (in_valid && !in_stall)
            begin
                predicted_outputs.push_back(predict_masker_output(in_data));
            end
            outputs_in_flight = predicted_outputs.size();
        end
    end

endmodule

FILE: tb/hot_pixel_history_masker_unit_tb.sv
// Testbench top for hot_pixel_history_masker_unit: clock, reset, requests, register writes,
// result stalls and the verdict. Depends on hphm_pkg and hot_pixel_mask_checker.
module hot_pixel_history_masker_unit_tb
    import hphm_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned PHASE_ITEMS   = 115;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    cfg_index_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    in_t                   in_data;
    logic                  out_valid;
    logic                  out_stall;
    out_t                  out_data;

    int          outputs_in_flight;
    int          mismatch_count;
    bit          steady_tail;
    int unsigned gap_percent;
    int unsigned hold_requests;
    int unsigned current_threshold;
    int unsigned sample_requests;
    int unsigned recompute_requests;
    int unsigned settings_written;
    int unsigned elapsed_cycles;

    hot_pixel_history_masker_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    hot_pixel_mask_checker mask_monitor (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .in_data           (in_data),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .out_data          (out_data),
        .outputs_in_flight (outputs_in_flight),
        .mismatch_count    (mismatch_count)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog on the total run length.
    initial
    begin
        elapsed_cycles = 0;
        while (elapsed_cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            elapsed_cycles++;
        end
        $display("hot_pixel_history_masker_unit verification failed");
        $finish;
    end

    // Result side: random stall bursts, quiet stretches and the requested long hold-offs.
    initial
    begin
        int unsigned burst;
        int unsigned run;
        int unsigned holds_served;
        out_stall = 1'b0;
        burst = 0;
        run = 0;
        holds_served = 0;
        forever
        begin
            @(negedge clk);
            if (holds_served < hold_requests)
            begin
                holds_served++;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else if (steady_tail)
            begin
                out_stall <= 1'b0;
            end
            else if (burst > 0)
            begin
                out_stall <= 1'b1;
                burst--;
            end
            else if (run > 0)
            begin
                out_stall <= 1'b0;
                run--;
            end
            else if ($urandom_range(2, 0) == 0)
            begin
                burst = $urandom_range(18, 1) - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                run = $urandom_range(40, 1) - 1;
                out_stall <= 1'b0;
            end
        end
    end

    // A sample value that is hot or not under the current threshold.
    function automatic logic [SAMPLE_W-1:0] pick_value(input bit want_hot);
        int unsigned magnitude;
        bit          negative;
        begin
            negative = 1'($urandom_range(1, 0));
            if (want_hot && current_threshold < 32768)
            begin
                magnitude = $urandom_range(32768, current_threshold + 1);
            end
            else
            begin
                magnitude = $urandom_range((current_threshold > 32767) ? 32767 :
                                           current_threshold, 0);
            end
            // Only the most negative sample reaches a magnitude of 32768.
            if (magnitude == 32768)
            begin
                negative = 1'b1;
            end
            return negative ? SAMPLE_W'(-int'(magnitude)) : SAMPLE_W'(magnitude);
        end
    endfunction

    function automatic in_t pixel_req(input int unsigned index, input int value, input bit eof);
        in_t req;
        begin
            req.action = ACT_SAMPLE;
            req.pixel_index = PIX_IDX_W'(index);
            req.pixel_value = SAMPLE_W'(value);
            req.end_of_frame = eof;
            return req;
        end
    endfunction

    // A recompute request carries random content in the fields it ignores.
    function automatic in_t recompute_req();
        in_t req;
        begin
            req.action = ACT_RECOMPUTE;
            req.pixel_index = PIX_IDX_W'($urandom);
            req.pixel_value = SAMPLE_W'($urandom);
            req.end_of_frame = 1'($urandom_range(1, 0));
            return req;
        end
    endfunction

    // Offers one request from a falling edge and returns at the falling edge after acceptance.
    task automatic offer(input in_t req);
        begin
            if (!steady_tail && $urandom_range(99, 0) < gap_percent)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(18, 1)) @(negedge clk);
            end
            in_data <= req;
            in_valid <= 1'b1;
            @(posedge clk);
            while (in_stall)
            begin
                @(posedge clk);
            end
            if (req.action == ACT_RECOMPUTE)
            begin
                recompute_requests++;
            end
            else
            begin
                sample_requests++;
            end
            @(negedge clk);
        end
    endtask

    // Holds requests back until every predicted result has come out.
    task automatic drain();
        begin
            in_valid <= 1'b0;
            while (outputs_in_flight != 0)
            begin
                @(negedge clk);
            end
            repeat (SETTLE_CYCLES) @(negedge clk);
        end
    endtask

    task automatic write_regs(input int unsigned threshold, input int unsigned cutoff);
        begin
            cfg_we <= 1'b1;
            cfg_index <= CFG_HOT_THRESHOLD;
            cfg_data <= CFG_DATA_W'(threshold);
            @(negedge clk);
            cfg_index <= CFG_HOT_COUNT_CUTOFF;
            cfg_data <= CFG_DATA_W'(cutoff);
            @(negedge clk);
            cfg_we <= 1'b0;
            current_threshold = threshold;
            settings_written++;
        end
    endtask

    // Frames over a small pixel window, a recompute every few frames, and some noise.
    task automatic run_frames(input int unsigned items);
        int unsigned base;
        int unsigned width;
        int unsigned frames;
        int unsigned sent;
        int unsigned hot_percent;
        in_t         req;
        begin
            base = $urandom_range(NUM_PIXELS_DEFAULT - 12, 0);
            frames = 0;
            sent = 0;
            while (sent < items)
            begin
                if ($urandom_range(99, 0) < 82)
                begin
                    width = $urandom_range(10, 2);
                    for (int k = 0; k < width; k++)
                    begin
                        // Every third pixel of the window runs hot most of the time.
                        hot_percent = ((k % 3) == 0) ? 85 : 15;
                        offer(pixel_req(base + k,
                                        int'(pick_value($urandom_range(99, 0) < hot_percent)),
                                        k == width - 1));
                    end
                    sent += width;
                    frames++;
                    if (frames % 5 == 0)
                    begin
                        offer(recompute_req());
                        sent++;
                    end
                end
                else
                begin
                    req = in_t'($bits(in_t)'($urandom));
                    req.action = ($urandom_range(9, 0) == 0) ? ACT_RECOMPUTE : ACT_SAMPLE;
                    offer(req);
                    sent++;
                end
            end
        end
    endtask

    // Main sequence: reset, directed requests, then random phases under several settings.
    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_HOT_THRESHOLD;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        steady_tail = 1'b0;
        gap_percent = 25;
        hold_requests = 0;
        current_threshold = 32'(HOT_THRESHOLD_RESET);
        sample_requests = 0;
        recompute_requests = 0;
        settings_written = 0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // Reset register values: extreme samples around the default threshold.
        offer(pixel_req(0, 32767, 1'b0));
        offer(pixel_req(4095, -32768, 1'b0));
        offer(pixel_req(12'hAAA, -32767, 1'b0));
        offer(pixel_req(12'h555, 0, 1'b1));
        offer(pixel_req(2048, 1, 1'b0));
        offer(recompute_req());

        // Zero threshold and zero cutoff: a recompute masks every pixel.
        drain();
        write_regs(0, 0);
        offer(pixel_req(7, 0, 1'b0));
        offer(pixel_req(7, -1, 1'b1));
        offer(recompute_req());
        offer(pixel_req(7, 12345, 1'b0));
        offer(pixel_req(4095, -32768, 1'b1));

        // Top threshold and cutoff: nothing is hot and nothing stays masked.
        drain();
        write_regs(32768, 64);
        offer(pixel_req(4095, -32768, 1'b0));
        offer(pixel_req(100, 32767, 1'b1));
        offer(recompute_req());
        offer(pixel_req(7, -5, 1'b0));

        // One hot frame is enough to mask a pixel.
        drain();
        write_regs(1, 1);
        offer(pixel_req(9, 2, 1'b1));
        offer(pixel_req(10, -1, 1'b1));
        offer(recompute_req());
        offer(pixel_req(9, 555, 1'b0));

        // Random phases.
        drain();
        write_regs(0, 1);
        run_frames(PHASE_ITEMS);

        drain();
        write_regs($urandom_range(4000, 0), 2);
        run_frames(50);
        // The result side holds off while requests keep coming back to back.
        gap_percent = 0;
        hold_requests++;
        repeat (25)
        begin
            offer(pixel_req($urandom_range(4095, 0),
                            int'(pick_value(1'($urandom_range(1, 0)))),
                            1'($urandom_range(1, 0))));
        end
        gap_percent = 30;
        run_frames(50);

        drain();
        write_regs($urandom_range(32768, 0), $urandom_range(64, 0));
        run_frames(PHASE_ITEMS);

        drain();
        gap_percent = 0;
        write_regs($urandom_range(1000, 0), 3);
        run_frames(PHASE_ITEMS);

        drain();
        gap_percent = 40;
        write_regs($urandom_range(2000, 0), $urandom_range(6, 1));
        run_frames(PHASE_ITEMS);

        // Last phase with no idling on either side.
        drain();
        steady_tail = 1'b1;
        write_regs($urandom_range(1500, 0), 1);
        run_frames(PHASE_ITEMS);
        drain();

        $display("Covered %0d pixel samples and %0d mask recomputes under %0d register settings,",
                 sample_requests, recompute_requests, settings_written + 1);
        $display("with result stalls, %0d long result hold-off(s) and sender pauses.",
                 hold_requests);
        if (mismatch_count == 0)
        begin
            $display("hot_pixel_history_masker_unit verification clean");
        end
        else
        begin
            $display("hot_pixel_history_masker_unit verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/hphm_pkg.sv
sv/hphm_entry_ram.sv
sv/hot_pixel_history_masker_unit.sv
tb/hot_pixel_mask_checker.sv
tb/hot_pixel_history_masker_unit_tb.sv
